>>> rtl/prq_pkg.sv
// Shared types and constants for the two-bank priority run queue.
package prq_pkg;

  localparam int CFG_W    = 5;
  localparam int PRIO_W   = 5;
  localparam int QLEVEL_W = 4;

  localparam logic [CFG_W-1:0] NUM_LEVELS_RST = 5'd4;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch item, decode, issue queue-state read, bank swap
    logic update;  // queue-state read data valid: perform queue update
    logic grab;    // entry read data valid: capture popped id
    logic emit;    // move finished result into output register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic early;   // result known at decode: range overflow or empty take
    logic take;    // latched item is a take
  } stat_t;

endpackage

>>> rtl/priority_run_queue_active_expired.sv
// Two-bank (active/expired) multilevel run queue, top level.
//
//   channel   handshake            payload
//   in        in_valid / in_stall  cmd, proc_id, current_priority, base_priority
//   out       out_valid / out_stall granted, chosen_id, queue_level, went_expired, overflow
//   cfg       cfg_we               cfg_wdata (num_levels)
//
// One command at a time. After the transfer an add passes S_QREAD and S_DONE, a take
// S_QREAD, S_TREAD and S_DONE, an add out of range or a take on empty banks only S_DONE;
// the input stalls until S_IDLE and the result is registered on leaving S_DONE. The cost
// is set by the registered reads of the queue-state RAM and then the entry RAM.
// A new command is taken while an earlier result waits in the output register; a
// second finished result holds the controller in its last state until the output frees.
// Reset clears bitmaps, bank select and per-queue valid bits.
module priority_run_queue_active_expired #(
  parameter int MAX_LEVELS  = 16,
  parameter int LEVEL_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [prq_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cmd,
  input  logic [ID_BITS-1:0]                proc_id,
  input  logic signed [prq_pkg::PRIO_W-1:0] current_priority,
  input  logic [prq_pkg::PRIO_W-1:0]        base_priority,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              granted,
  output logic [ID_BITS-1:0]                chosen_id,
  output logic [prq_pkg::QLEVEL_W-1:0]      queue_level,
  output logic                              went_expired,
  output logic                              overflow
);
  import prq_pkg::*;

  ctl_t  ctl;
  stat_t st;

  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .st        (st)
  );

  prq_dp #(
    .MAX_LEVELS  (MAX_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .st               (st),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .proc_id          (proc_id),
    .current_priority (current_priority),
    .base_priority    (base_priority),
    .granted          (granted),
    .chosen_id        (chosen_id),
    .queue_level      (queue_level),
    .went_expired     (went_expired),
    .overflow         (overflow)
  );

endmodule

>>> rtl/prq_ram.sv
// Generic simple dual-port RAM with registered read.
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/prq_ctrl.sv
// Sequencing state machine for the run queue.
module prq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output prq_pkg::ctl_t   ctl,
  input  prq_pkg::stat_t  st
);
  import prq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_QREAD = 4'b0010,
    S_TREAD = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    ctl            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.accept = 1'b1;
          state_next = st.early ? S_DONE : S_QREAD;
        end
      end
      S_QREAD: begin
        ctl.update = 1'b1;
        state_next = st.take ? S_TREAD : S_DONE;
      end
      S_TREAD: begin
        ctl.grab   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/prq_dp.sv
// Run queue datapath: bitmaps, queue state, entry store and result registers.
module prq_dp #(
  parameter int MAX_LEVELS  = 16,
  parameter int LEVEL_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  prq_pkg::ctl_t                 ctl,
  output prq_pkg::stat_t                st,
  input  logic                          cfg_we,
  input  logic [prq_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          cmd,
  input  logic [ID_BITS-1:0]            proc_id,
  input  logic signed [prq_pkg::PRIO_W-1:0] current_priority,
  input  logic [prq_pkg::PRIO_W-1:0]    base_priority,
  output logic                          granted,
  output logic [ID_BITS-1:0]            chosen_id,
  output logic [prq_pkg::QLEVEL_W-1:0]  queue_level,
  output logic                          went_expired,
  output logic                          overflow
);
  import prq_pkg::*;

  localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PAD_W  = 1 << LVL_W;
  localparam int Q_W    = LVL_W + 1;
  localparam int QN     = 1 << Q_W;
  localparam int SLOT_W = $clog2(LEVEL_DEPTH);
  localparam int SUM_W  = SLOT_W + 1;
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int QS_W   = SLOT_W + CNT_W;
  localparam int EA_W   = Q_W + SLOT_W;
  localparam int EN     = 1 << EA_W;

  // index of the highest set bit, halving search
  function automatic logic [LVL_W-1:0] top_level(input logic [MAX_LEVELS-1:0] v);
    logic [PAD_W-1:0] w;
    logic [PAD_W-1:0] hi;
    logic [PAD_W-1:0] low_mask;
    logic [LVL_W-1:0] idx;
    w   = PAD_W'(v);
    idx = '0;
    for (int b = LVL_W - 1; b >= 0; b--) begin
      low_mask = (PAD_W'(1) << (1 << b)) - PAD_W'(1);
      hi       = (w >> (1 << b)) & low_mask;
      if (hi != '0) begin
        idx[b] = 1'b1;
        w      = hi;
      end else begin
        w = w & low_mask;
      end
    end
    return idx;
  endfunction

  logic [CFG_W-1:0]            num_levels;
  logic [1:0][MAX_LEVELS-1:0]  masks;
  logic                        active_bank;
  logic [QN-1:0]               qvalid;

  // latched item
  logic              item_take;
  logic              item_exp;
  logic [Q_W-1:0]    item_q;
  logic [ID_BITS-1:0] item_id;
  logic              item_qv;

  // working result
  logic               res_granted;
  logic [ID_BITS-1:0] res_id;
  logic [QLEVEL_W-1:0] res_level;
  logic               res_exp;
  logic               res_ovf;

  // decode
  logic              is_take;
  logic              expired;
  logic [PRIO_W-1:0] lvl_raw;
  logic              range_bad;
  logic              add_bank;
  logic              act_empty;
  logic              eff_bank;
  logic [MAX_LEVELS-1:0] eff_mask;
  logic [LVL_W-1:0]  take_lvl;
  logic [Q_W-1:0]    q_dec;

  assign is_take   = (cmd == CMD_TAKE);
  assign expired   = current_priority[PRIO_W-1];
  assign lvl_raw   = expired ? (base_priority - PRIO_W'(1)) : $unsigned(current_priority);
  assign range_bad = (expired && (base_priority == '0)) ||
                     (lvl_raw >= num_levels) ||
                     (32'(lvl_raw) >= 32'(MAX_LEVELS));
  assign add_bank  = expired ? ~active_bank : active_bank;
  assign act_empty = (masks[active_bank] == '0);
  assign eff_bank  = act_empty ? ~active_bank : active_bank;
  assign eff_mask  = masks[eff_bank];
  assign take_lvl  = top_level(eff_mask);
  assign q_dec     = is_take ? {eff_bank, take_lvl} : {add_bank, LVL_W'(lvl_raw)};

  assign st.early = is_take ? (eff_mask == '0) : range_bad;
  assign st.take  = item_take;

  // queue state: head and count per bank and level
  logic [QS_W-1:0]   qs_rdata;
  logic [QS_W-1:0]   qs_wdata;
  logic              qs_we;
  logic [SLOT_W-1:0] head;
  logic [CNT_W-1:0]  cnt;
  logic              full;
  logic [SUM_W-1:0]  tail_sum;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] head_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic [LVL_W-1:0]  item_lvl;
  logic              item_bank;

  assign item_lvl  = item_q[LVL_W-1:0];
  assign item_bank = item_q[Q_W-1];
  assign head      = item_qv ? qs_rdata[QS_W-1:CNT_W] : '0;
  assign cnt       = item_qv ? qs_rdata[CNT_W-1:0] : '0;
  assign full      = (cnt == CNT_W'(LEVEL_DEPTH));
  assign tail_sum  = SUM_W'(head) + SUM_W'(cnt);
  assign tail      = (tail_sum >= SUM_W'(LEVEL_DEPTH)) ?
                     SLOT_W'(tail_sum - SUM_W'(LEVEL_DEPTH)) : SLOT_W'(tail_sum);
  assign head_inc  = (head == SLOT_W'(LEVEL_DEPTH - 1)) ? '0 : head + SLOT_W'(1);
  assign cnt_dec   = (cnt == '0) ? '0 : cnt - CNT_W'(1);

  assign qs_we    = ctl.update && (item_take || !full);
  assign qs_wdata = item_take ? {head_inc, cnt_dec} : {head, cnt + CNT_W'(1)};

  prq_ram #(
    .WIDTH (QS_W),
    .DEPTH (QN)
  ) u_qstate (
    .clk   (clk),
    .we    (qs_we),
    .waddr (item_q),
    .wdata (qs_wdata),
    .re    (ctl.accept),
    .raddr (q_dec),
    .rdata (qs_rdata)
  );

  // entry store
  logic               es_we;
  logic               es_re;
  logic [ID_BITS-1:0] es_rdata;

  assign es_we = ctl.update && !item_take && !full;
  assign es_re = ctl.update && item_take;

  prq_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (EN)
  ) u_entries (
    .clk   (clk),
    .we    (es_we),
    .waddr ({item_q, tail}),
    .wdata (item_id),
    .re    (es_re),
    .raddr ({item_q, head}),
    .rdata (es_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      num_levels  <= NUM_LEVELS_RST;
      masks       <= '0;
      active_bank <= 1'b0;
      qvalid      <= '0;
    end else begin
      if (cfg_we) begin
        num_levels <= cfg_wdata;
      end
      if (ctl.accept && is_take && act_empty) begin
        active_bank <= ~active_bank;
      end
      if (qs_we) begin
        qvalid[item_q] <= 1'b1;
      end
      if (ctl.update) begin
        if (!item_take && !full) begin
          masks[item_bank][item_lvl] <= 1'b1;
        end else if (item_take && (cnt_dec == '0)) begin
          masks[item_bank][item_lvl] <= 1'b0;
        end
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_take   <= is_take;
      item_exp    <= expired && !is_take;
      item_q      <= q_dec;
      item_id     <= proc_id;
      item_qv     <= qvalid[q_dec];
      res_granted <= 1'b0;
      res_id      <= '0;
      res_level   <= '0;
      res_exp     <= 1'b0;
      res_ovf     <= !is_take;
    end
    if (ctl.update) begin
      if (item_take) begin
        res_granted <= 1'b1;
        res_level   <= QLEVEL_W'(item_lvl);
      end else if (full) begin
        res_ovf <= 1'b1;
      end else begin
        res_level <= QLEVEL_W'(item_lvl);
        res_exp   <= item_exp;
        res_ovf   <= 1'b0;
      end
    end
    if (ctl.grab) begin
      res_id <= es_rdata;
    end
    if (ctl.emit) begin
      granted      <= res_granted;
      chosen_id    <= res_id;
      queue_level  <= res_level;
      went_expired <= res_exp;
      overflow     <= res_ovf;
    end
  end

endmodule

>>> rtl/prq_checker.sv
// Port-level assertions for the run queue, bound to the top level.
module prq_checker #(
  parameter int ID_BITS = 8
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         granted,
  input logic [ID_BITS-1:0]           chosen_id,
  input logic [prq_pkg::QLEVEL_W-1:0] queue_level,
  input logic                         went_expired,
  input logic                         overflow
);

  // one command in flight: a transfer closes the input for the next cycle
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chosen_id) && $stable(granted))
    else $error("stalled result changed");

  a_take_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> !went_expired && !overflow)
    else $error("take result carries add flags");

  a_no_grant_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> chosen_id == '0)
    else $error("id returned without grant");

  a_ovf_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> queue_level == '0 && !went_expired)
    else $error("dropped add reports a level");

endmodule

bind priority_run_queue_active_expired prq_checker #(
  .ID_BITS (ID_BITS)
) u_prq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .granted      (granted),
  .chosen_id    (chosen_id),
  .queue_level  (queue_level),
  .went_expired (went_expired),
  .overflow     (overflow)
);
